### rtl/realized_variance_accumulator_top_defines.svh
// assertion macros for the realized variance accumulator
`ifndef REALIZED_VARIANCE_ACCUMULATOR_TOP_DEFINES_SVH
`define REALIZED_VARIANCE_ACCUMULATOR_TOP_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define RVA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RVA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/rva_pkg.sv
// ----------------------------------------------------------------------------
// rva_pkg
// types and constants of the realized variance accumulator
// ----------------------------------------------------------------------------
package rva_pkg;

    localparam logic [2:0] ST_ACCRUED   = 3'd0;
    localparam logic [2:0] ST_SEEDED    = 3'd1;
    localparam logic [2:0] ST_CLOSED    = 3'd2;
    localparam logic [2:0] ST_REJECTED  = 3'd3;
    localparam logic [2:0] ST_RESTARTED = 3'd4;

    localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

    localparam logic [0:0] REG_ANNUALIZATION = 1'b0;
    localparam logic [0:0] REG_OBS_TOTAL     = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_NORM,
        S_SQUARE,
        S_NEXT_LOG,
        S_LN_HI,
        S_LN_LO,
        S_SQR,
        S_ACC,
        S_ANN_HI,
        S_ANN_LO,
        S_DIV_GO,
        S_DIV,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] variance;
        logic [15:0] obs_done;
        logic [2:0]  status;
        logic        desync;
        logic        saturated;
    } result_t;

    typedef struct packed {
        logic        new_series;
        logic [31:0] spot_price;
    } request_t;

endpackage

### rtl/rva_stream_if.sv
// ----------------------------------------------------------------------------
// rva_stream_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface rva_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/realized_variance_accumulator_top.sv
// ----------------------------------------------------------------------------
// realized_variance_accumulator_top
// realized variance of one price series, iterative fixed-point engine
// ----------------------------------------------------------------------------
// channel   dir  payload
// req       in   new_series, spot_price
// res       out  variance, obs_done, status, desync, saturated
// apb       in   annualization @0x0, obs_total @0x4
//
// an accruing price runs from accept to result valid through two log2 runs of L
// squarings on the shared multiplier, L being LOG_ITERATIONS clamped to 16..48,
// seven scale and accumulate steps, a serial 64 by 16 bit divide and the output state
// restart, zero, seed and closed requests go straight to the output state
// the result waits in an output register; the next request is taken once it leaves
// rst_n clears all series state and sets both registers to 252
module realized_variance_accumulator_top
    import rva_pkg::*;
#(
    parameter int LOG_ITERATIONS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    rva_stream_if.sink   req,
    rva_stream_if.source res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] annualization, obs_total;
    logic        busy, done;
    result_t     core_res;
    logic        out_valid_reg;
    result_t     out_reg;

    rva_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .annualization (annualization),
        .obs_total     (obs_total)
    );

    rva_core #(.LOG_ITERATIONS(LOG_ITERATIONS)) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (req.valid && req.ready),
        .req           (req.data),
        .annualization (annualization),
        .obs_total     (obs_total),
        .busy          (busy),
        .done          (done),
        .res           (core_res)
    );

    assign req.ready = !busy && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= core_res;
        end
    end

    assign res.valid = out_valid_reg;
    assign res.data  = out_reg;

endmodule

### rtl/rva_divider.sv
// ----------------------------------------------------------------------------
// rva_divider
// radix-2 restoring divider, 64 by 16 bits, one quotient bit a cycle
// ----------------------------------------------------------------------------
module rva_divider
    import rva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] quo_reg, quo_next;
    logic [16:0] rem_reg, rem_next;
    logic [15:0] div_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [16:0] trial;
    logic [17:0] diff;

    always_comb
    begin
        trial     = {rem_reg[15:0], quo_reg[63]};
        diff      = {1'b0, trial} - {2'b00, div_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 7'd0;
            rem_next  = '0;
            quo_next  = dividend;
        end
        else if (busy_reg)
        begin
            if (!diff[17])
            begin
                rem_next = diff[16:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'd63)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
        begin
            div_reg <= divisor;
        end
    end

    assign done     = busy_reg && (cnt_reg == 7'd63);
    assign quotient = quo_next;

endmodule

### rtl/rva_core.sv
// ----------------------------------------------------------------------------
// rva_core
// sequencer around one shared 33x33 multiplier: log2 squarings, ln2 scale,
// return square, annualization, then a serial divide
// ----------------------------------------------------------------------------
module rva_core
    import rva_pkg::*;
#(
    parameter int LOG_ITERATIONS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  request_t    req,
    input  logic [15:0] annualization,
    input  logic [15:0] obs_total,
    output logic        busy,
    output logic        done,
    output result_t     res
);

    localparam int LOG_FRAC = (LOG_ITERATIONS < 16) ? 16 :
                              ((LOG_ITERATIONS > 48) ? 48 : LOG_ITERATIONS);
    localparam int LW = LOG_FRAC + 6;
    localparam int IW = $clog2(LOG_FRAC + 1);

    state_t state_reg, state_next;

    logic [31:0] prev_reg;
    logic        seeded_reg;
    logic [63:0] sum_reg;
    logic [15:0] count_reg;
    logic        desync_reg;
    logic [31:0] var_reg;

    logic [31:0] spot_reg;
    logic        which_reg;        // 0: log of spot, 1: log of previous
    logic [32:0] m_reg;
    logic [LOG_FRAC-1:0] frac_reg;
    logic [4:0]  p_reg;
    logic [IW-1:0] it_reg;
    logic signed [LW-1:0] la_reg;
    logic [LW-1:0] mag_reg;
    logic [63:0] acc_reg;
    logic [31:0] r_reg;
    logic [2:0]  status_reg;

    // shared multiplier
    logic [32:0] mul_a, mul_b;
    logic [65:0] prod;
    assign prod = mul_a * mul_b;

    logic [31:0] src;
    logic [4:0]  lead;
    logic [65:0] sq_shift;
    logic signed [LW-1:0] log_val;
    logic signed [LW-1:0] diff;
    logic [63:0] mag32;
    logic [64:0] sum_add;
    logic [63:0] term;

    logic        div_start, div_done;
    logic [63:0] div_q;

    rva_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (acc_reg),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        src  = which_reg ? prev_reg : spot_reg;
        lead = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (src[i])
            begin
                lead = 5'(i);
            end
        end
        sq_shift = prod >> 31;
        log_val  = $signed(LW'($signed({1'b0, p_reg}) - 7'sd16) <<< LOG_FRAC)
                 + $signed({1'b0, frac_reg});
        diff     = la_reg - log_val;
        if (LOG_FRAC >= 32)
        begin
            mag32 = 64'(mag_reg >> (LOG_FRAC - 32));
        end
        else
        begin
            mag32 = 64'(mag_reg) << (32 - LOG_FRAC);
        end
        term    = 64'((prod + 66'd8) >> 4);
        // squared return is held in acc_reg from the cycle before
        sum_add = {1'b0, sum_reg} + {1'b0, acc_reg};

        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SQUARE:
            begin
                mul_a = m_reg;
                mul_b = m_reg;
            end
            S_LN_HI:
            begin
                mul_a = {1'b0, mag32[63:32]};
                mul_b = {1'b0, LN2_Q32};
            end
            S_LN_LO:
            begin
                mul_a = {1'b0, mag32[31:0]};
                mul_b = {1'b0, LN2_Q32};
            end
            S_SQR:
            begin
                mul_a = {1'b0, r_reg};
                mul_b = {1'b0, r_reg};
            end
            S_ANN_HI:
            begin
                mul_a = {1'b0, sum_reg[63:32]};
                mul_b = {17'd0, annualization};
            end
            S_ANN_LO:
            begin
                mul_a = {1'b0, sum_reg[31:0]};
                mul_b = {17'd0, annualization};
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (req.new_series || (req.spot_price == 32'd0) || !seeded_reg
                        || (count_reg >= obs_total))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_NORM;
                    end
                end
            end
            S_NORM:     state_next = S_SQUARE;
            S_SQUARE:
            begin
                if (it_reg == IW'(LOG_FRAC - 1))
                begin
                    state_next = S_NEXT_LOG;
                end
            end
            S_NEXT_LOG: state_next = which_reg ? S_LN_HI : S_NORM;
            S_LN_HI:    state_next = S_LN_LO;
            S_LN_LO:    state_next = S_SQR;
            S_SQR:      state_next = S_ACC;
            S_ACC:      state_next = S_ANN_HI;
            S_ANN_HI:   state_next = S_ANN_LO;
            S_ANN_LO:   state_next = S_DIV_GO;
            // dividend in acc_reg is complete here
            S_DIV_GO:
            begin
                state_next = S_DIV;
                div_start  = 1'b1;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:      state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            prev_reg   <= '0;
            seeded_reg <= 1'b0;
            sum_reg    <= '0;
            count_reg  <= '0;
            desync_reg <= 1'b0;
            var_reg    <= '0;
            status_reg <= ST_ACCRUED;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && start)
            begin
                if (req.new_series)
                begin
                    prev_reg   <= '0;
                    seeded_reg <= 1'b0;
                    sum_reg    <= '0;
                    count_reg  <= '0;
                    desync_reg <= 1'b0;
                    var_reg    <= '0;
                    status_reg <= ST_RESTARTED;
                end
                else if (req.spot_price == 32'd0)
                begin
                    desync_reg <= 1'b1;
                    status_reg <= ST_REJECTED;
                end
                else if (!seeded_reg)
                begin
                    prev_reg   <= req.spot_price;
                    seeded_reg <= 1'b1;
                    status_reg <= ST_SEEDED;
                end
                else if (count_reg >= obs_total)
                begin
                    status_reg <= ST_CLOSED;
                end
                else
                begin
                    status_reg <= ST_ACCRUED;
                end
            end
            if (state_reg == S_ACC)
            begin
                sum_reg   <= sum_add[64] ? '1 : sum_add[63:0];
                count_reg <= count_reg + 16'd1;
                prev_reg  <= spot_reg;
            end
            if (state_reg == S_DIV && div_done)
            begin
                var_reg <= (div_q[63:32] != 32'd0) ? '1 : div_q[31:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                spot_reg  <= req.spot_price;
                which_reg <= 1'b0;
            end
            S_NORM:
            begin
                p_reg    <= lead;
                m_reg    <= {1'b0, src << (5'd31 - lead)};
                frac_reg <= '0;
                it_reg   <= '0;
            end
            S_SQUARE:
            begin
                it_reg <= it_reg + IW'(1);
                if (sq_shift[32])
                begin
                    m_reg    <= sq_shift[33:1];
                    frac_reg <= {frac_reg[LOG_FRAC-2:0], 1'b1};
                end
                else
                begin
                    m_reg    <= sq_shift[32:0];
                    frac_reg <= {frac_reg[LOG_FRAC-2:0], 1'b0};
                end
            end
            S_NEXT_LOG:
            begin
                which_reg <= 1'b1;
                if (!which_reg)
                begin
                    la_reg <= log_val;
                end
                else
                begin
                    mag_reg <= diff[LW-1] ? LW'(-diff) : LW'(diff);
                end
            end
            S_LN_HI: acc_reg <= 64'(prod);
            S_LN_LO:
            begin
                r_reg <= 32'((acc_reg + 64'(prod >> 32) + 64'd32) >> 6);
            end
            S_SQR:    acc_reg <= term;
            S_ANN_HI: acc_reg <= 64'(prod) << 8;
            S_ANN_LO: acc_reg <= acc_reg + 64'(prod >> 24);
            default:
            begin
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_OUT);

    always_comb
    begin
        res.variance  = var_reg;
        res.obs_done  = count_reg;
        res.status    = status_reg;
        res.desync    = desync_reg;
        res.saturated = (sum_reg == '1) || (var_reg == '1);
    end

endmodule

### rtl/rva_regs.sv
// ----------------------------------------------------------------------------
// rva_regs
// apb configuration registers
// ----------------------------------------------------------------------------
module rva_regs
    import rva_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [15:0] annualization,
    output logic [15:0] obs_total
);

    logic [15:0] ann_reg, tot_reg;
    logic        wr;

    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ann_reg <= 16'd252;
            tot_reg <= 16'd252;
        end
        else if (wr && paddr[1:0] == 2'b00)
        begin
            unique case (paddr[2])
                REG_ANNUALIZATION: ann_reg <= pwdata[15:0];
                REG_OBS_TOTAL:     tot_reg <= pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_ANNUALIZATION: prdata = {16'd0, ann_reg};
            REG_OBS_TOTAL:     prdata = {16'd0, tot_reg};
            default:           prdata = '0;
        endcase
    end

    assign annualization = ann_reg;
    assign obs_total     = tot_reg;

endmodule

### rtl/rva_checker.sv
// ----------------------------------------------------------------------------
// rva_checker
// port-level checks of the accumulator
// ----------------------------------------------------------------------------
`include "realized_variance_accumulator_top_defines.svh"

module rva_checker
    import rva_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    in_valid,
    input logic    in_ready,
    input logic    out_valid,
    input logic    out_ready,
    input result_t out_data,
    input logic    pready
);

    `RVA_ASSERT_IMP(a_no_ready_while_out, clk, rst_n, out_valid, !in_ready)
    `RVA_ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_valid && in_ready, !in_ready)
    `RVA_ASSERT_IMP(a_status_range, clk, rst_n, out_valid, out_data.status <= ST_RESTARTED)
    `RVA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
    `RVA_ASSERT_IMP(a_pready, clk, rst_n, 1'b1, pready)

endmodule

bind realized_variance_accumulator_top rva_checker u_rva_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (res.data),
    .pready    (pready)
);

### tb/realized_variance_accumulator_top_tb.sv
// ----------------------------------------------------------------------------
// realized_variance_accumulator_top_tb
// drives price requests and apb register writes, predicts each result with a
// fixed-point model of the log-return accumulator and checks every field
// ----------------------------------------------------------------------------
module realized_variance_accumulator_top_tb
    import rva_pkg::*;
();

    localparam int LOG_FRAC = 32;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 800;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rva_stream_if #(.payload_t(request_t)) req_if ();
    rva_stream_if #(.payload_t(result_t))  res_if ();

    realized_variance_accumulator_top u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_if),
        .res     (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor state
    logic [15:0] ann_reg;
    logic [15:0] total_reg;
    logic [31:0] prev_price;
    logic        prev_seen;
    logic [63:0] sum_sq;
    logic [15:0] count_done;
    logic        desync_flag;
    logic [31:0] last_var;

    result_t expected_q[$];
    int      error_count;
    int      idle_count;
    bit      no_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint log2_q(input logic [31:0] x);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 31;
        while (p > 0 && x[p] == 1'b0)
            p--;
        m = 64'(x) << (31 - p);
        frac = 0;
        for (int i = 0; i < LOG_FRAC; i++)
        begin
            m = (m * m) >> 31;
            frac = frac << 1;
            if (m >= 64'h1_0000_0000)
            begin
                frac[0] = 1'b1;
                m = m >> 1;
            end
        end
        return longint'(p - 16) * (longint'(1) << LOG_FRAC) + longint'(frac);
    endfunction

    function automatic logic [63:0] ln_return_mag(input logic [31:0] a, input logic [31:0] b);
        longint      d;
        logic [63:0] mag;
        logic [63:0] hi_part;
        logic [63:0] lo_part;
        d = log2_q(a) - log2_q(b);
        mag = (d < 0) ? 64'(-d) : 64'(d);
        hi_part = (mag >> 32) * 64'(LN2_Q32);
        lo_part = (mag & 64'hFFFF_FFFF) * 64'(LN2_Q32);
        return (hi_part + (lo_part >> 32) + 64'd32) >> 6;
    endfunction

    function automatic logic [31:0] annualized_var();
        logic [63:0] q;
        logic [63:0] v;
        if (count_done == 0)
            return 32'd0;
        q = ((64'(ann_reg) * (sum_sq >> 32)) << 8)
            + ((64'(ann_reg) * (sum_sq & 64'hFFFF_FFFF)) >> 24);
        v = q / 64'(count_done);
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic result_t predict_fixing(input request_t rq);
        result_t     r;
        logic [63:0] ret;
        logic [63:0] term;
        if (rq.new_series)
        begin
            prev_price = 0;
            prev_seen = 0;
            sum_sq = 0;
            count_done = 0;
            desync_flag = 0;
            last_var = 0;
            r.status = ST_RESTARTED;
        end
        else if (rq.spot_price == 0)
        begin
            desync_flag = 1;
            r.status = ST_REJECTED;
        end
        else if (!prev_seen)
        begin
            prev_price = rq.spot_price;
            prev_seen = 1;
            r.status = ST_SEEDED;
        end
        else if (count_done >= total_reg)
            r.status = ST_CLOSED;
        else
        begin
            ret = ln_return_mag(rq.spot_price, prev_price);
            term = (ret * ret + 64'd8) >> 4;
            if (term > ~sum_sq)
                sum_sq = '1;
            else
                sum_sq = sum_sq + term;
            count_done = count_done + 16'd1;
            prev_price = rq.spot_price;
            last_var = annualized_var();
            r.status = ST_ACCRUED;
        end
        r.variance = last_var;
        r.obs_done = count_done;
        r.desync = desync_flag;
        r.saturated = (sum_sq == '1) || (last_var == '1);
        return r;
    endfunction

    function automatic void check_result(input result_t exp, input result_t act);
        if (act.variance !== exp.variance)
        begin
            $error("variance exp %h got %h", exp.variance, act.variance);
            error_count++;
        end
        if (act.obs_done !== exp.obs_done)
        begin
            $error("obs_done exp %0d got %0d", exp.obs_done, act.obs_done);
            error_count++;
        end
        if (act.status !== exp.status)
        begin
            $error("status exp %0d got %0d", exp.status, act.status);
            error_count++;
        end
        if (act.desync !== exp.desync)
        begin
            $error("desync exp %0d got %0d", exp.desync, act.desync);
            error_count++;
        end
        if (act.saturated !== exp.saturated)
        begin
            $error("saturated exp %0d got %0d", exp.saturated, act.saturated);
            error_count++;
        end
    endfunction

    // valid is dropped only when an idle gap follows
    task automatic random_idle(input int pct);
        if (!no_stall && $urandom_range(99) < pct)
        begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(8, 1)) @(posedge clk);
        end
    endtask

    task automatic drop_request();
        req_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apb_write(input logic [0:0] idx, input logic [15:0] value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= {16'($urandom_range(65535)), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == REG_ANNUALIZATION)
            ann_reg = value;
        else
            total_reg = value;
    endtask

    task automatic send_with(input request_t rq, input result_t e);
        random_idle(25);
        req_if.valid <= 1'b1;
        req_if.data <= rq;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        expected_q.insert(expected_q.size(), e);
    endtask

    task automatic send_fixing(input request_t rq);
        send_with(rq, predict_fixing(rq));
    endtask

    task automatic wait_drained();
        drop_request();
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    // sink side with random back-pressure, held ready in the no-stall phase
    always @(posedge clk)
    begin
        if (!rst_n)
            res_if.ready <= 1'b0;
        else if (no_stall)
            res_if.ready <= 1'b1;
        else if (res_if.ready && $urandom_range(99) < 12)
            res_if.ready <= 1'b0;
        else if (!res_if.ready && $urandom_range(99) < 30)
            res_if.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && res_if.valid && res_if.ready)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no request pending");
                error_count++;
            end
            else
            begin
                e = expected_q.pop_front();
                check_result(e, res_if.data);
            end
        end
    end

    // watchdog on cycles without any accepted request or result or apb access
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel)
            idle_count <= 0;
        else
            idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG_LIMIT)
        begin
            $display("realized_variance_accumulator_top_tb: errors");
            $finish;
        end
    end

    typedef struct {
        request_t rq;
        bit       has_golden;
        result_t  golden;
    } stim_row_t;

    function automatic stim_row_t row(input logic ns, input logic [31:0] p, input bit g,
                                      input logic [2:0] st, input logic ds);
        stim_row_t s;
        s.rq.new_series = ns;
        s.rq.spot_price = p;
        s.has_golden = g;
        s.golden = '0;
        s.golden.status = st;
        s.golden.desync = ds;
        return s;
    endfunction

    function automatic request_t rand_fixing(input logic [31:0] base);
        request_t rq;
        int       k;
        k = $urandom_range(99);
        rq.new_series = (k < 3);
        if (k < 6)
            rq.spot_price = 0;
        else if (k < 12)
            rq.spot_price = $urandom;
        else if (k < 15)
            rq.spot_price = $urandom_range(3, 1);
        else
            rq.spot_price = base + $urandom_range(4096) - 32'd2048;
        if (rq.spot_price == 0 && k >= 6)
            rq.spot_price = 1;
        if (k < 3)
            rq.spot_price = $urandom;
        return rq;
    endfunction

    initial
    begin
        stim_row_t   dir[$];
        result_t     g;
        request_t    rq;
        logic [31:0] base;
        rst_n = 1'b0;
        psel = 0;
        penable = 0;
        pwrite = 0;
        paddr = 0;
        pwdata = 0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        res_if.ready = 1'b0;
        error_count = 0;
        idle_count = 0;
        no_stall = 0;
        ann_reg = 252;
        total_reg = 252;
        prev_price = 0;
        prev_seen = 0;
        sum_sq = 0;
        count_done = 0;
        desync_flag = 0;
        last_var = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: seed, extremes, zero price, restart
        dir = {dir, row(1'b0, 32'd0, 1, ST_REJECTED, 1'b1)};
        dir = {dir, row(1'b1, 32'hFFFF_FFFF, 1, ST_RESTARTED, 1'b0)};
        dir = {dir, row(1'b0, 32'hFFFF_FFFF, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'h0000_0001, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'hFFFF_FFFF, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'h0001_0000, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'h0001_0000, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'd0, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'h0001_8000, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b1, 32'd0, 1, ST_RESTARTED, 1'b0)};
        dir = {dir, row(1'b0, 32'h0064_0000, 0, ST_ACCRUED, 1'b0)};
        dir = {dir, row(1'b0, 32'h0065_0000, 0, ST_ACCRUED, 1'b0)};
        foreach (dir[i])
        begin
            g = predict_fixing(dir[i].rq);
            if (dir[i].has_golden)
            begin
                check_result(dir[i].golden, g);
                g = dir[i].golden;
            end
            send_with(dir[i].rq, g);
        end
        wait_drained();

        // closure with tiny obs_total, minimum annualization
        apb_write(REG_OBS_TOTAL, 16'd1);
        apb_write(REG_ANNUALIZATION, 16'd1);
        send_fixing('{1'b1, 32'd0});
        send_fixing('{1'b0, 32'h0002_0000});
        send_fixing('{1'b0, 32'h0003_0000});
        send_fixing('{1'b0, 32'h0004_0000});
        send_fixing('{1'b0, 32'd0});
        wait_drained();

        // maximum annualization drives the variance to its ceiling
        apb_write(REG_ANNUALIZATION, 16'hFFFF);
        apb_write(REG_OBS_TOTAL, 16'hFFFF);
        send_fixing('{1'b1, 32'd0});
        send_fixing('{1'b0, 32'h0000_0001});
        send_fixing('{1'b0, 32'hFFFF_FFFF});
        send_fixing('{1'b0, 32'h0000_0001});
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    apb_write(REG_ANNUALIZATION, 16'd252);
                    apb_write(REG_OBS_TOTAL, 16'd20);
                end
                1:
                begin
                    apb_write(REG_ANNUALIZATION, 16'd1);
                    apb_write(REG_OBS_TOTAL, 16'hFFFF);
                end
                2:
                begin
                    apb_write(REG_ANNUALIZATION, 16'($urandom_range(65535, 1)));
                    apb_write(REG_OBS_TOTAL, 16'($urandom_range(60, 1)));
                end
                default:
                begin
                    apb_write(REG_ANNUALIZATION, 16'hFFFF);
                    apb_write(REG_OBS_TOTAL, 16'd30);
                end
            endcase
            if (ph == 3)
                no_stall = 1;
            base = $urandom_range(32'h00FF_0000, 32'h0001_0000);
            for (int n = 0; n < N_RANDOM / 4; n++)
            begin
                rq = rand_fixing(base);
                if (rq.spot_price != 0 && !rq.new_series)
                    base = rq.spot_price < 32'd4096 ? 32'd4096 : rq.spot_price;
                send_fixing(rq);
                // one hold-off until the result queue empties
                if (ph == 1 && n == 50)
                begin
                    drop_request();
                    while (expected_q.size() != 0)
                        @(posedge clk);
                end
            end
            wait_drained();
        end

        if (error_count == 0)
            $display("realized_variance_accumulator_top_tb: clean");
        else
            $display("realized_variance_accumulator_top_tb: errors");
        $finish;
    end
endmodule

### sim.f
+incdir+rtl
rtl/rva_pkg.sv
rtl/rva_stream_if.sv
rtl/rva_divider.sv
rtl/rva_core.sv
rtl/rva_regs.sv
rtl/realized_variance_accumulator_top.sv
rtl/rva_checker.sv
tb/realized_variance_accumulator_top_tb.sv
